FILE: rtl/core/lsi2c_pkg.sv
// ----------------------------------------------------------------------------
// lsi2c_pkg
// Shared types and codes of the LED shadow store with its I2C write master.
// ----------------------------------------------------------------------------
package lsi2c_pkg;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_FLUSH = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR   = 2'd0,
    CFG_FRAME_REG  = 2'd1,
    CFG_UPDATE_REG = 2'd2,
    CFG_UPDATE_VAL = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_STA_A = 4'd1,
    PH_STA_B = 4'd2,
    PH_STA_C = 4'd3,
    PH_BIT_A = 4'd4,
    PH_BIT_B = 4'd5,
    PH_BIT_C = 4'd6,
    PH_ACK_A = 4'd7,
    PH_ACK_B = 4'd8,
    PH_ACK_C = 4'd9,
    PH_STO_A = 4'd10,
    PH_STO_B = 4'd11,
    PH_STO_C = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    SDA_LOW  = 2'd0,
    SDA_HIGH = 2'd1,
    SDA_DATA = 2'd2
  } sda_src_t;

  typedef enum logic [2:0] {
    POS_HOLD      = 3'd0,
    POS_CLEAR     = 3'd1,
    POS_FIRST     = 3'd2,
    POS_NEXT_BIT  = 3'd3,
    POS_NEXT_BYTE = 3'd4,
    POS_TXN2      = 3'd5
  } pos_op_t;

  typedef struct packed {
    logic     store_we;
    logic     flush;
    pos_op_t  pos_op;
    logic     line_we;
    logic     scl;
    sda_src_t sda_src;
    logic     ack_we;
    logic     txn_set;
    logic     txn_clear;
  } cmd_t;

  typedef struct packed {
    logic dirty;
    logic last_bit;
    logic more_bytes;
    logic txn2;
  } sts_t;

  localparam logic [6:0] DEV_ADDR_RST   = 7'h3C;
  localparam logic [7:0] FRAME_REG_RST  = 8'h01;
  localparam logic [7:0] UPDATE_REG_RST = 8'h25;
  localparam logic [7:0] UPDATE_VAL_RST = 8'h01;

endpackage

FILE: rtl/core/led_shadow_i2c_flush_master_top.sv
// the result strobe follows each accepted item on the next cycle
// throughput: one item per cycle, busy never rises
// a tick moves the bus one phase, three to a bit, so a full flush takes
//   27 * (CHANNELS + 5) + 11 ticks after the flush item
// reset: synchronous; levels zero, store clean, bus idle with both lines released
// the receiver cannot stall the results
// ----------------------------------------------------------------------------
// led_shadow_i2c_flush_master_top
// LED level shadow store that flushes itself over a bit-banged I2C write.
// ----------------------------------------------------------------------------
module led_shadow_i2c_flush_master_top #(
  parameter int CHANNELS = 21
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [4:0] channel,
  input  logic [7:0] level,
  input  logic       sda_in,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic       scl_out,
  output logic       sda_out,
  output logic       busy_res,
  output logic       last_ack,
  output logic       dirty
);

  lsi2c_pkg::cmd_t cmd;
  lsi2c_pkg::sts_t sts;
  logic            accept;

  // every item completes in the cycle it is accepted
  assign busy   = 1'b0;
  assign accept = start && !busy;

  lsi2c_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .func     (lsi2c_pkg::func_t'(func)),
    .sts      (sts),
    .cmd      (cmd),
    .busy_res (busy_res),
    .done     (done)
  );

  lsi2c_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .channel   (channel),
    .level     (level),
    .sda_in    (sda_in),
    .cfg_we    (cfg_we),
    .cfg_index (lsi2c_pkg::cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .scl_out   (scl_out),
    .sda_out   (sda_out),
    .last_ack  (last_ack),
    .dirty     (dirty)
  );

`ifndef ASSERT_OFF
  // idle bus leaves both lines released
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    !busy_res |-> (scl_out && sda_out))
    else $error("lines not released while bus idle");

  // a flush that starts the bus always leaves the store clean
  a_flush_clean: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(busy_res)) |-> !dirty)
    else $error("dirty flag still set after flush start");

  // the clock line only moves on a tick transfer
  a_scl_tick: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (scl_out != $past(scl_out)))
      |-> $past(accept && (func == lsi2c_pkg::FUNC_TICK)))
    else $error("clock line moved without a tick");

  // the store only turns dirty through a set transfer
  a_dirty_set: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(dirty))
      |-> $past(accept && (func == lsi2c_pkg::FUNC_SET)))
    else $error("dirty flag set without a level write");
`endif

endmodule

FILE: rtl/core/lsi2c_ctrl.sv
// ----------------------------------------------------------------------------
// lsi2c_ctrl
// Bus phase state machine: decodes each item and commands the datapath.
// ----------------------------------------------------------------------------
module lsi2c_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lsi2c_pkg::func_t    func,
  input  lsi2c_pkg::sts_t     sts,
  output lsi2c_pkg::cmd_t     cmd,
  output logic                busy_res,
  output logic                done
);

  lsi2c_pkg::phase_t phase;
  lsi2c_pkg::phase_t phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lsi2c_pkg::PH_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= start;
    end
  end

  assign busy_res = (phase != lsi2c_pkg::PH_IDLE);

  always_comb begin
    phase_next = phase;
    cmd        = '0;
    if (start) begin
      unique case (func)
        lsi2c_pkg::FUNC_SET: begin
          cmd.store_we = 1'b1;
        end
        lsi2c_pkg::FUNC_FLUSH: begin
          if (sts.dirty && (phase == lsi2c_pkg::PH_IDLE)) begin
            phase_next    = lsi2c_pkg::PH_STA_A;
            cmd.flush     = 1'b1;
            cmd.pos_op    = lsi2c_pkg::POS_CLEAR;
            cmd.txn_clear = 1'b1;
            cmd.line_we   = 1'b1;
            cmd.scl       = 1'b1;
            cmd.sda_src   = lsi2c_pkg::SDA_HIGH;
          end
        end
        lsi2c_pkg::FUNC_TICK: begin
          cmd.line_we = (phase != lsi2c_pkg::PH_IDLE);
          unique case (phase)
            lsi2c_pkg::PH_STA_A: begin
              phase_next = lsi2c_pkg::PH_STA_B;
              cmd.scl = 1'b1;  cmd.sda_src = lsi2c_pkg::SDA_LOW;
            end
            lsi2c_pkg::PH_STA_B: begin
              phase_next = lsi2c_pkg::PH_STA_C;
              cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_LOW;
            end
            lsi2c_pkg::PH_STA_C: begin
              phase_next = lsi2c_pkg::PH_BIT_A;
              cmd.pos_op = lsi2c_pkg::POS_FIRST;
              cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_DATA;
            end
            lsi2c_pkg::PH_BIT_A: begin
              phase_next = lsi2c_pkg::PH_BIT_B;
              cmd.scl = 1'b1;  cmd.sda_src = lsi2c_pkg::SDA_DATA;
            end
            lsi2c_pkg::PH_BIT_B: begin
              phase_next = lsi2c_pkg::PH_BIT_C;
              cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_DATA;
            end
            lsi2c_pkg::PH_BIT_C: begin
              if (!sts.last_bit) begin
                phase_next = lsi2c_pkg::PH_BIT_A;
                cmd.pos_op = lsi2c_pkg::POS_NEXT_BIT;
                cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_DATA;
              end else begin
                phase_next = lsi2c_pkg::PH_ACK_A;
                cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_HIGH;
              end
            end
            lsi2c_pkg::PH_ACK_A: begin
              phase_next = lsi2c_pkg::PH_ACK_B;
              cmd.scl = 1'b1;  cmd.sda_src = lsi2c_pkg::SDA_HIGH;
            end
            lsi2c_pkg::PH_ACK_B: begin
              phase_next = lsi2c_pkg::PH_ACK_C;
              cmd.ack_we = 1'b1;
              cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_HIGH;
            end
            lsi2c_pkg::PH_ACK_C: begin
              if (sts.more_bytes) begin
                phase_next = lsi2c_pkg::PH_BIT_A;
                cmd.pos_op = lsi2c_pkg::POS_NEXT_BYTE;
                cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_DATA;
              end else begin
                phase_next = lsi2c_pkg::PH_STO_A;
                cmd.scl = 1'b0;  cmd.sda_src = lsi2c_pkg::SDA_LOW;
              end
            end
            lsi2c_pkg::PH_STO_A: begin
              phase_next = lsi2c_pkg::PH_STO_B;
              cmd.scl = 1'b1;  cmd.sda_src = lsi2c_pkg::SDA_LOW;
            end
            lsi2c_pkg::PH_STO_B: begin
              cmd.scl = 1'b1;  cmd.sda_src = lsi2c_pkg::SDA_HIGH;
              if (sts.txn2) begin
                phase_next    = lsi2c_pkg::PH_IDLE;
                cmd.txn_clear = 1'b1;
              end else begin
                phase_next = lsi2c_pkg::PH_STO_C;
              end
            end
            lsi2c_pkg::PH_STO_C: begin
              // second transaction restarts from the device address
              phase_next  = lsi2c_pkg::PH_STA_A;
              cmd.txn_set = 1'b1;
              cmd.pos_op  = lsi2c_pkg::POS_TXN2;
              cmd.scl = 1'b1;  cmd.sda_src = lsi2c_pkg::SDA_HIGH;
            end
            default: begin
              cmd.line_we = 1'b0;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/lsi2c_dpath.sv
// ----------------------------------------------------------------------------
// lsi2c_dpath
// Level store, configuration registers, byte and bit positions, bus lines.
// ----------------------------------------------------------------------------
module lsi2c_dpath #(
  parameter int CHANNELS = 21
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lsi2c_pkg::cmd_t       cmd,
  input  logic [4:0]            channel,
  input  logic [7:0]            level,
  input  logic                  sda_in,
  input  logic                  cfg_we,
  input  lsi2c_pkg::cfg_idx_t   cfg_index,
  input  logic [7:0]            cfg_data,
  output lsi2c_pkg::sts_t       sts,
  output logic                  scl_out,
  output logic                  sda_out,
  output logic                  last_ack,
  output logic                  dirty
);

  localparam int BYTE_W = $clog2(CHANNELS + 2);
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [BYTE_W:0] TXN1_BYTES = (BYTE_W + 1)'(CHANNELS + 2);
  localparam logic [BYTE_W:0] TXN2_BYTES = (BYTE_W + 1)'(3);

  logic [6:0]        dev_addr;
  logic [7:0]        frame_reg;
  logic [7:0]        update_reg;
  logic [7:0]        update_val;
  logic [7:0]        store [CHANNELS];
  logic              txn2;
  logic [BYTE_W-1:0] byte_pos;
  logic [BYTE_W-1:0] byte_pos_next;
  logic [2:0]        bit_pos;
  logic [2:0]        bit_pos_next;
  logic [BYTE_W-1:0] lvl_off;
  logic [7:0]        tx_byte;
  logic              data_bit;
  logic              set_hit;
  logic              sda_sel;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr   <= lsi2c_pkg::DEV_ADDR_RST;
      frame_reg  <= lsi2c_pkg::FRAME_REG_RST;
      update_reg <= lsi2c_pkg::UPDATE_REG_RST;
      update_val <= lsi2c_pkg::UPDATE_VAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsi2c_pkg::CFG_DEV_ADDR:   dev_addr   <= cfg_data[6:0];
        lsi2c_pkg::CFG_FRAME_REG:  frame_reg  <= cfg_data;
        lsi2c_pkg::CFG_UPDATE_REG: update_reg <= cfg_data;
        lsi2c_pkg::CFG_UPDATE_VAL: update_val <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a set only counts when it lands in range and changes the value
  assign set_hit = cmd.store_we && (channel < 5'(CHANNELS))
                   && (store[channel[IDX_W-1:0]] != level);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        store[i] <= '0;
      end
    end else if (set_hit) begin
      store[channel[IDX_W-1:0]] <= level;
    end
  end

  always_comb begin
    byte_pos_next = byte_pos;
    bit_pos_next  = bit_pos;
    unique case (cmd.pos_op)
      lsi2c_pkg::POS_HOLD: begin
      end
      lsi2c_pkg::POS_CLEAR: begin
        byte_pos_next = '0;
        bit_pos_next  = '0;
      end
      lsi2c_pkg::POS_FIRST: begin
        byte_pos_next = '0;
        bit_pos_next  = 3'd7;
      end
      lsi2c_pkg::POS_NEXT_BIT: begin
        bit_pos_next = bit_pos - 3'd1;
      end
      lsi2c_pkg::POS_NEXT_BYTE: begin
        byte_pos_next = byte_pos + BYTE_W'(1);
        bit_pos_next  = 3'd7;
      end
      lsi2c_pkg::POS_TXN2: begin
        byte_pos_next = '0;
      end
      default: begin
      end
    endcase
  end

  // byte on the wire, picked from the position after this phase
  assign lvl_off = byte_pos_next - BYTE_W'(2);

  always_comb begin
    if (byte_pos_next == '0) begin
      tx_byte = {dev_addr, 1'b0};
    end else if (txn2) begin
      tx_byte = (byte_pos_next == BYTE_W'(1)) ? update_reg : update_val;
    end else if (byte_pos_next == BYTE_W'(1)) begin
      tx_byte = frame_reg;
    end else if (lvl_off < BYTE_W'(CHANNELS)) begin
      tx_byte = store[lvl_off[IDX_W-1:0]];
    end else begin
      tx_byte = '0;
    end
  end

  assign data_bit = tx_byte[bit_pos_next];

  always_comb begin
    unique case (cmd.sda_src)
      lsi2c_pkg::SDA_LOW:  sda_sel = 1'b0;
      lsi2c_pkg::SDA_HIGH: sda_sel = 1'b1;
      lsi2c_pkg::SDA_DATA: sda_sel = data_bit;
      default:             sda_sel = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
      bit_pos  <= '0;
      txn2     <= 1'b0;
      scl_out  <= 1'b1;
      sda_out  <= 1'b1;
      last_ack <= 1'b0;
      dirty    <= 1'b0;
    end else begin
      byte_pos <= byte_pos_next;
      bit_pos  <= bit_pos_next;
      if (cmd.txn_set) begin
        txn2 <= 1'b1;
      end else if (cmd.txn_clear) begin
        txn2 <= 1'b0;
      end
      if (cmd.line_we) begin
        scl_out <= cmd.scl;
        sda_out <= sda_sel;
      end
      if (cmd.ack_we) begin
        last_ack <= !sda_in;
      end
      if (set_hit) begin
        dirty <= 1'b1;
      end else if (cmd.flush) begin
        dirty <= 1'b0;
      end
    end
  end

  assign sts.dirty      = dirty;
  assign sts.last_bit   = (bit_pos == 3'd0);
  assign sts.more_bytes = ({1'b0, byte_pos} + (BYTE_W + 1)'(1))
                          < (txn2 ? TXN2_BYTES : TXN1_BYTES);
  assign sts.txn2       = txn2;

endmodule
